/* rtl/jhbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jhbc_pkg;

	localparam int VAL_W      = 16;
	localparam int BIN_W      = 8;
	localparam int CNT_W      = 32;
	localparam int PROB_W     = 16;
	localparam int BINS_REG_W = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [PROB_W-1:0] PROB_ONE = 16'h8000;

	localparam logic KIND_ACC  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INT_LOW   = 3'd0,
		REG_INT_HIGH  = 3'd1,
		REG_GRAD_HIGH = 3'd2,
		REG_INT_BINS  = 3'd3,
		REG_GRAD_BINS = 3'd4,
		REG_ACT_THR   = 3'd5
	} cfg_reg_t;

	typedef logic [BIN_W-1:0] bin_t;

endpackage

`default_nettype wire

/* rtl/jhbc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface jhbc_item_if import jhbc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic signed [VAL_W-1:0] intensity;
	logic [VAL_W-1:0]        gradient;
	logic                    label;
	bin_t                    read_intensity_bin;
	bin_t                    read_gradient_bin;

	modport source (
		output valid, kind, intensity, gradient, label, read_intensity_bin, read_gradient_bin,
		input  ready
	);
	modport sink (
		input  valid, kind, intensity, gradient, label, read_intensity_bin, read_gradient_bin,
		output ready
	);
endinterface

interface jhbc_result_if import jhbc_pkg::*; ();
	logic              valid;
	logic              ready;
	bin_t              intensity_bin;
	bin_t              gradient_bin;
	logic [CNT_W-1:0]  total_count;
	logic [CNT_W-1:0]  labeled_count;
	logic [PROB_W-1:0] probability;
	logic              active;

	modport source (
		output valid, intensity_bin, gradient_bin, total_count, labeled_count, probability,
		output active,
		input  ready
	);
	modport sink (
		input  valid, intensity_bin, gradient_bin, total_count, labeled_count, probability,
		input  active,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/jhbc_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module jhbc_div #(
	parameter int DVW = 47,
	parameter int DSW = 32,
	parameter int QW  = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DVW-1:0] dividend,
	input  wire logic [DSW-1:0] divisor,
	output logic                done,
	output logic [QW-1:0]       quotient
);

	localparam int SW  = DSW + QW - 1;
	localparam int CW  = (DVW > SW) ? DVW : SW;
	localparam int STW = $clog2(QW + 1);

	logic [CW-1:0]  rem_q;
	logic [CW-1:0]  dsr_q;
	logic [QW-1:0]  quo_q;
	logic [STW-1:0] step_q;
	logic           busy_q;
	logic           done_q;
	logic           fits;

	// restoring division, one quotient bit per cycle, msb first
	assign fits = rem_q >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STW'(QW);
			end else if (busy_q) begin
				step_q <= step_q - STW'(1);
				if (step_q == STW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CW'(dividend);
			dsr_q <= CW'(divisor) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			quo_q <= {quo_q[QW-2:0], fits};
			dsr_q <= dsr_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/joint_histogram_bin_classifier_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// 2d joint histogram of intensity and gradient with labeled counts
// item channel: valid/ready beats, kind 0 accumulates one voxel, kind 1 reads one bin
// result channel: valid/ready beats, exactly one result beat per item beat, in order
// config port: cfg_we/cfg_index/cfg_data, to be written by the user only while no
// item is in flight, which the block does not enforce; one item is worked at a time;
// the state lives in two count memories with registered reads; an item passes
// intensity binning, gradient binning, the memory read, the update and the
// probability step, then waits to load the result; one shared 16-step restoring
// divider serves the intensity bin, the gradient bin and the probability, so an
// accumulate item may use it up to three times and a read item at most once; the
// next item is taken while a result still waits in the output register
// reset: registers take their defaults, then a clearing pass writes zero to all
// MAX_INTENSITY_BINS * MAX_GRADIENT_BINS bins (65536 by default), during which
// item ready is low; config writes are taken throughout
// receiver stall: the result is held stable, the next item is worked up to
// its result and then waits, and no further item is taken

module joint_histogram_bin_classifier_core import jhbc_pkg::*; #(
	parameter int MAX_INTENSITY_BINS = 256,
	parameter int MAX_GRADIENT_BINS  = 256,
	parameter int COUNT_BITS         = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	jhbc_item_if.sink                  item,
	jhbc_result_if.source              result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IBW   = $clog2(MAX_INTENSITY_BINS);
	localparam int GBW   = $clog2(MAX_GRADIENT_BINS);
	localparam int INW   = $clog2(MAX_INTENSITY_BINS + 1);
	localparam int GNW   = $clog2(MAX_GRADIENT_BINS + 1);
	localparam int NW    = (INW > GNW) ? INW : GNW;
	localparam int DEPTH = MAX_INTENSITY_BINS * MAX_GRADIENT_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int BDW   = VAL_W + NW;
	localparam int PDW   = COUNT_BITS + PROB_W - 1;
	localparam int DVW   = (BDW > PDW) ? BDW : PDW;
	localparam int DSW   = (COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W;
	localparam int MW    = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_BIN_I = 4'd2;
	localparam logic [3:0] ST_DIV_I = 4'd3;
	localparam logic [3:0] ST_BIN_G = 4'd4;
	localparam logic [3:0] ST_DIV_G = 4'd5;
	localparam logic [3:0] ST_READ  = 4'd6;
	localparam logic [3:0] ST_UPD   = 4'd7;
	localparam logic [3:0] ST_PROB  = 4'd8;
	localparam logic [3:0] ST_DIV_P = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	// config registers
	logic signed [VAL_W-1:0] int_low_q;
	logic signed [VAL_W-1:0] int_high_q;
	logic [VAL_W-1:0]        grad_high_q;
	logic [BINS_REG_W-1:0]   int_bins_q;
	logic [BINS_REG_W-1:0]   grad_bins_q;
	logic [CNT_W-1:0]        act_thr_q;

	// item in flight
	logic [3:0]              state_q;
	logic [AW-1:0]           clr_q;
	logic                    kind_q;
	logic                    label_q;
	logic signed [VAL_W-1:0] ival_q;
	logic [VAL_W-1:0]        gval_q;
	bin_t                    rbi_q;
	bin_t                    rbg_q;
	logic [IBW-1:0]          bi_q;
	logic [GBW-1:0]          bg_q;
	logic [COUNT_BITS-1:0]   tot_q;
	logic [COUNT_BITS-1:0]   lab_q;
	logic                    act_q;
	logic [PROB_W-1:0]       prob_q;

	// result register
	logic                    res_valid_q;
	bin_t                    res_bi_q;
	bin_t                    res_bg_q;
	logic [CNT_W-1:0]        res_tot_q;
	logic [CNT_W-1:0]        res_lab_q;
	logic [PROB_W-1:0]       res_prob_q;
	logic                    res_act_q;

	// count memories
	logic [COUNT_BITS-1:0]   tot_mem [DEPTH];
	logic [COUNT_BITS-1:0]   lab_mem [DEPTH];
	logic [COUNT_BITS-1:0]   rd_tot_q;
	logic [COUNT_BITS-1:0]   rd_lab_q;
	logic                    mem_we;
	logic [AW-1:0]           addr;
	logic [AW-1:0]           waddr;
	logic [COUNT_BITS-1:0]   wtot;
	logic [COUNT_BITS-1:0]   wlab;
	logic [COUNT_BITS-1:0]   new_tot;
	logic [COUNT_BITS-1:0]   new_lab;

	// binning
	logic [INW-1:0]          ni;
	logic [GNW-1:0]          ng;
	logic signed [VAL_W:0]   i_diff;
	logic signed [VAL_W:0]   i_span;
	logic                    i_special;
	logic                    i_over;
	logic                    g_special;
	logic                    g_over;
	logic [BDW-1:0]          i_prod;
	logic [BDW-1:0]          g_prod;
	logic [IBW-1:0]          i_read_bin;
	logic [GBW-1:0]          g_read_bin;
	logic                    act;

	// shared divider
	logic                    div_start;
	logic [DVW-1:0]          div_dvd;
	logic [DSW-1:0]          div_dsr;
	logic                    div_done;
	logic [PROB_W-1:0]       div_quo;

	logic                    item_fire;
	logic                    res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_low_q   <= -16'sd1024;
			int_high_q  <= 16'sd1024;
			grad_high_q <= 16'd1024;
			int_bins_q  <= 9'd64;
			grad_bins_q <= 9'd64;
			act_thr_q   <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INT_LOW:   int_low_q   <= cfg_data[VAL_W-1:0];
				REG_INT_HIGH:  int_high_q  <= cfg_data[VAL_W-1:0];
				REG_GRAD_HIGH: grad_high_q <= cfg_data[VAL_W-1:0];
				REG_INT_BINS:  int_bins_q  <= cfg_data[BINS_REG_W-1:0];
				REG_GRAD_BINS: grad_bins_q <= cfg_data[BINS_REG_W-1:0];
				REG_ACT_THR:   act_thr_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int_bins_q == '0) begin
			ni = INW'(1);
		end else if (int_bins_q > MAX_INTENSITY_BINS) begin
			ni = INW'(MAX_INTENSITY_BINS);
		end else begin
			ni = INW'(int_bins_q);
		end
		if (grad_bins_q == '0) begin
			ng = GNW'(1);
		end else if (grad_bins_q > MAX_GRADIENT_BINS) begin
			ng = GNW'(MAX_GRADIENT_BINS);
		end else begin
			ng = GNW'(grad_bins_q);
		end
	end

	assign i_diff    = {ival_q[VAL_W-1], ival_q} - {int_low_q[VAL_W-1], int_low_q};
	assign i_span    = {int_high_q[VAL_W-1], int_high_q} - {int_low_q[VAL_W-1], int_low_q};
	// empty or reversed range, or value below the low edge
	assign i_special = i_span[VAL_W] || (i_span == '0) || i_diff[VAL_W];
	assign i_over    = i_diff[VAL_W-1:0] >= i_span[VAL_W-1:0];
	assign i_prod    = BDW'(i_diff[VAL_W-1:0]) * BDW'(ni);
	assign g_special = grad_high_q == '0;
	assign g_over    = gval_q >= grad_high_q;
	assign g_prod    = BDW'(gval_q) * BDW'(ng);

	assign i_read_bin = (16'(rbi_q) >= 16'(ni)) ? IBW'(ni - INW'(1)) : IBW'(rbi_q);
	assign g_read_bin = (16'(rbg_q) >= 16'(ng)) ? GBW'(ng - GNW'(1)) : GBW'(rbg_q);

	assign act = MW'(tot_q) >= MW'(act_thr_q);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVW'(i_prod);
		div_dsr   = DSW'(i_span[VAL_W-1:0]);
		case (state_q)
			ST_BIN_I: begin
				div_start = (kind_q == KIND_ACC) && !i_special && !i_over;
			end
			ST_BIN_G: begin
				div_start = (kind_q == KIND_ACC) && !g_special && !g_over;
				div_dvd   = DVW'(g_prod);
				div_dsr   = DSW'(grad_high_q);
			end
			ST_PROB: begin
				div_start = act && (tot_q != '0);
				div_dvd   = DVW'({lab_q, {(PROB_W-1){1'b0}}});
				div_dsr   = DSW'(tot_q);
			end
			default: ;
		endcase
	end

	jhbc_div #(
		.DVW (DVW),
		.DSW (DSW),
		.QW  (PROB_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	// memory access
	assign addr    = AW'(bg_q) * AW'(MAX_INTENSITY_BINS) + AW'(bi_q);
	assign new_tot = (rd_tot_q != CNT_MAX) ? rd_tot_q + COUNT_BITS'(1) : rd_tot_q;
	assign new_lab = (label_q && rd_lab_q != CNT_MAX) ? rd_lab_q + COUNT_BITS'(1) : rd_lab_q;
	assign mem_we  = (state_q == ST_CLEAR) || (state_q == ST_UPD && kind_q == KIND_ACC);
	assign waddr   = (state_q == ST_CLEAR) ? clr_q : addr;
	assign wtot    = (state_q == ST_CLEAR) ? '0 : new_tot;
	assign wlab    = (state_q == ST_CLEAR) ? '0 : new_lab;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tot_mem[waddr] <= wtot;
			lab_mem[waddr] <= wlab;
		end
		rd_tot_q <= tot_mem[addr];
		rd_lab_q <= lab_mem[addr];
	end

	assign item_fire = item.valid && item.ready;
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE:  if (item_fire) state_q <= ST_BIN_I;
				ST_BIN_I: state_q <= div_start ? ST_DIV_I : ST_BIN_G;
				ST_DIV_I: if (div_done) state_q <= ST_BIN_G;
				ST_BIN_G: state_q <= div_start ? ST_DIV_G : ST_READ;
				ST_DIV_G: if (div_done) state_q <= ST_READ;
				ST_READ:  state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_PROB;
				ST_PROB:  state_q <= div_start ? ST_DIV_P : ST_DONE;
				ST_DIV_P: if (div_done) state_q <= ST_DONE;
				ST_DONE:  if (res_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			kind_q  <= item.kind;
			label_q <= item.label;
			ival_q  <= item.intensity;
			gval_q  <= item.gradient;
			rbi_q   <= item.read_intensity_bin;
			rbg_q   <= item.read_gradient_bin;
		end
		case (state_q)
			ST_BIN_I: begin
				if (kind_q == KIND_READ) begin
					bi_q <= i_read_bin;
				end else if (i_special) begin
					bi_q <= '0;
				end else begin
					bi_q <= IBW'(ni - INW'(1));
				end
			end
			ST_DIV_I: if (div_done) bi_q <= IBW'(div_quo);
			ST_BIN_G: begin
				if (kind_q == KIND_READ) begin
					bg_q <= g_read_bin;
				end else if (g_special) begin
					bg_q <= '0;
				end else begin
					bg_q <= GBW'(ng - GNW'(1));
				end
			end
			ST_DIV_G: if (div_done) bg_q <= GBW'(div_quo);
			ST_UPD: begin
				tot_q <= (kind_q == KIND_ACC) ? new_tot : rd_tot_q;
				lab_q <= (kind_q == KIND_ACC) ? new_lab : rd_lab_q;
			end
			ST_PROB: begin
				act_q  <= act;
				prob_q <= '0;
			end
			ST_DIV_P: begin
				if (div_done) begin
					prob_q <= (div_quo > PROB_ONE) ? PROB_ONE : div_quo;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_bi_q   <= BIN_W'(bi_q);
			res_bg_q   <= BIN_W'(bg_q);
			res_tot_q  <= CNT_W'(tot_q);
			res_lab_q  <= CNT_W'(lab_q);
			res_prob_q <= prob_q;
			res_act_q  <= act_q;
		end
	end

	assign item.ready           = state_q == ST_IDLE;
	assign result.valid         = res_valid_q;
	assign result.intensity_bin = res_bi_q;
	assign result.gradient_bin  = res_bg_q;
	assign result.total_count   = res_tot_q;
	assign result.labeled_count = res_lab_q;
	assign result.probability   = res_prob_q;
	assign result.active        = res_act_q;

endmodule

`default_nettype wire

/* rtl/jhbc_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module jhbc_chk import jhbc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [CNT_W-1:0]  out_total,
	input wire logic [PROB_W-1:0] out_probability,
	input wire logic              out_active
);

	// one item at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while another is in flight");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_total)
			&& $stable(out_probability) && $stable(out_active))
		else $error("stalled result beat changed");

	a_prob_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_probability <= PROB_ONE)
		else $error("probability above one");

	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_active |-> out_probability == '0)
		else $error("inactive bin with nonzero probability");

endmodule

bind joint_histogram_bin_classifier_core jhbc_chk u_jhbc_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (item.valid),
	.in_ready        (item.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.out_total       (result.total_count),
	.out_probability (result.probability),
	.out_active      (result.active)
);

`default_nettype wire
